[design/utf16_to_utf8_encoder_core_macros.svh]
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core_macros
// Assertion macros shared by the encoder core modules.
// Each check is a clocked property with reset disable.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_ENCODER_CORE_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define U16U8_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define U16U8_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define U16U8_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define U16U8_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[design/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and byte encoders for the UTF-16 to UTF-8 encoder core.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    // Configuration register indexes
    localparam logic CfgReplaceInvalid = 1'b0;
    localparam logic CfgSwapInputBytes = 1'b1;

    // Surrogate ranges are tagged by the top six bits (D800..DBFF, DC00..DFFF)
    localparam logic [5:0] HighSurrTag = 6'b110110;
    localparam logic [5:0] LowSurrTag  = 6'b110111;

    // Replacement character U+FFFD in UTF-8
    localparam logic [7:0] ReplByte0 = 8'hEF;
    localparam logic [7:0] ReplByte1 = 8'hBF;
    localparam logic [7:0] ReplByte2 = 8'hBD;

    localparam logic [15:0] TwoByteLimit = 16'h0800;
    localparam logic [20:0] SuppBase     = 21'h10000;
    localparam logic [5:0]  ContMask     = 6'h3F;

    localparam int MaxBurst = 6;

    // One decoded item: up to six words, byte 0 goes out first
    typedef struct packed {
        logic [2:0]                      cnt;
        logic [MaxBurst-1:0][7:0]        bytes;
        logic                            err;
        logic                            fin;
    } burst_t;

    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } bmp_enc_t;

    // Encode a BMP scalar as 1 to 3 bytes
    function automatic bmp_enc_t enc_bmp(input logic [15:0] cp);
        bmp_enc_t r;
        r = '0;
        if (cp[15:7] == 9'd0) begin
            r.cnt      = 2'd1;
            r.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < TwoByteLimit) begin
            r.cnt      = 2'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0] & ContMask};
        end else begin
            r.cnt      = 2'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // Encode a surrogate pair as 4 bytes
    function automatic logic [3:0][7:0] enc_supp(input logic [9:0] hi,
                                                 input logic [9:0] lo);
        logic [20:0]     cp;
        logic [3:0][7:0] r;
        cp   = {1'b0, hi, lo} + SuppBase;
        r[0] = {5'b11110, cp[20:18]};
        r[1] = {2'b10, cp[17:12]};
        r[2] = {2'b10, cp[11:6]};
        r[3] = {2'b10, cp[5:0]};
        return r;
    endfunction

endpackage

[design/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front
// Input register, surrogate pairing state and per-word decode into a burst.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_encoder_core_macros.svh"

module u16u8_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_code_unit,
    input  logic              s_string_end,
    input  logic              replace_invalid,
    input  logic              swap_input_bytes,
    input  logic              burst_free,
    output logic              burst_valid,
    output u16u8_pkg::burst_t burst
);

    logic        in_valid_reg;
    logic [15:0] in_unit_reg;
    logic        in_end_reg;
    logic        in_adv;

    logic        pend_reg, pend_next;
    logic [9:0]  hb_reg, hb_next;
    logic        fail_reg, fail_next;

    logic [15:0]          u;
    logic                 is_high, is_low;
    u16u8_pkg::bmp_enc_t  bmp;
    logic [2:0][7:0]      n_bytes;
    logic [1:0]           n_cnt;
    logic                 n_err;
    u16u8_pkg::burst_t    b;

    // Input register advances when the burst stage can take a new item
    assign in_adv  = in_valid_reg & burst_free;
    assign s_ready = ~in_valid_reg | in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_unit_reg <= s_code_unit;
            in_end_reg  <= s_string_end;
        end
    end

    // Decode one word against the held surrogate state
    always_comb begin
        u       = swap_input_bytes ? {in_unit_reg[7:0], in_unit_reg[15:8]} : in_unit_reg;
        is_high = (u[15:10] == u16u8_pkg::HighSurrTag);
        is_low  = (u[15:10] == u16u8_pkg::LowSurrTag);
        bmp     = u16u8_pkg::enc_bmp(u);

        b         = '0;
        b.fin     = in_end_reg;
        pend_next = pend_reg;
        hb_next   = hb_reg;
        fail_next = fail_reg;
        n_bytes   = '0;
        n_cnt     = 2'd0;
        n_err     = 1'b0;

        priority if (fail_reg) begin
            // dropping the rest of a failed string
            b.cnt = 3'd0;
        end else if (pend_reg && is_low) begin
            b.bytes[3:0] = u16u8_pkg::enc_supp(hb_reg, u[9:0]);
            b.cnt        = 3'd4;
            pend_next    = 1'b0;
            hb_next      = '0;
        end else if (pend_reg && !replace_invalid) begin
            n_err = 1'b1;
        end else begin
            pend_next = 1'b0;
            hb_next   = '0;
            // the word on its own
            if (is_high) begin
                if (in_end_reg) begin
                    n_err   = ~replace_invalid;
                    n_bytes = {u16u8_pkg::ReplByte2, u16u8_pkg::ReplByte1,
                               u16u8_pkg::ReplByte0};
                    n_cnt   = 2'd3;
                end else begin
                    pend_next = 1'b1;
                    hb_next   = u[9:0];
                end
            end else if (is_low) begin
                n_err   = ~replace_invalid;
                n_bytes = {u16u8_pkg::ReplByte2, u16u8_pkg::ReplByte1,
                           u16u8_pkg::ReplByte0};
                n_cnt   = 2'd3;
            end else begin
                n_bytes = bmp.bytes;
                n_cnt   = bmp.cnt;
            end
            // unpaired held high in replace mode puts U+FFFD first
            if (!n_err) begin
                if (pend_reg) begin
                    b.bytes[2:0] = {u16u8_pkg::ReplByte2, u16u8_pkg::ReplByte1,
                                    u16u8_pkg::ReplByte0};
                    b.bytes[5:3] = n_bytes;
                    b.cnt        = 3'd3 + {1'b0, n_cnt};
                end else begin
                    b.bytes[2:0] = n_bytes;
                    b.cnt        = {1'b0, n_cnt};
                end
            end
        end

        // strict-mode error: one flagged word, string fails until its end
        if (n_err) begin
            b         = '0;
            b.cnt     = 3'd1;
            b.err     = 1'b1;
            b.fin     = 1'b1;
            pend_next = 1'b0;
            hb_next   = '0;
            fail_next = 1'b1;
        end

        if (in_end_reg) begin
            pend_next = 1'b0;
            hb_next   = '0;
            fail_next = 1'b0;
        end
    end

    assign burst       = b;
    assign burst_valid = in_adv & (b.cnt != 3'd0);

    // Surrogate and failure state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            hb_reg   <= '0;
            fail_reg <= 1'b0;
        end else if (in_adv) begin
            pend_reg <= pend_next;
            hb_reg   <= hb_next;
            fail_reg <= fail_next;
        end
    end

    `U16U8_ASSERT_IMP(a_fail_no_pend, aclk, aresetn, fail_reg, !pend_reg, "failed with pending high")
    `U16U8_ASSERT_IMP(a_err_single, aclk, aresetn, burst_valid && burst.err,
                      burst.cnt == 3'd1 && burst.fin, "error burst not single final word")
    `U16U8_ASSERT_IMP(a_burst_cnt, aclk, aresetn, burst_valid, burst.cnt <= 3'd6, "burst above six words")

endmodule

[design/u16u8_serial.sv]
// ----------------------------------------------------------------------------
// u16u8_serial
// Burst register that sends one decoded item out one word per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_encoder_core_macros.svh"

module u16u8_serial (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              burst_valid,
    input  u16u8_pkg::burst_t burst,
    output logic              burst_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_utf8_byte,
    output logic              m_run_last,
    output logic              m_output_end,
    output logic              m_bad_sequence
);

    logic                                    busy_reg, busy_next;
    logic [2:0]                              rem_reg, rem_next;
    logic [u16u8_pkg::MaxBurst-1:0][7:0]     bytes_reg, bytes_next;
    logic                                    err_reg;
    logic                                    fin_reg;
    logic                                    take, last, finishing;

    assign take       = busy_reg & m_ready;
    assign last       = (rem_reg == 3'd1);
    assign finishing  = take & last;
    assign burst_free = ~busy_reg | finishing;

    // Load a new burst, else shift out the word just taken
    always_comb begin
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        bytes_next = bytes_reg;
        if (burst_valid) begin
            busy_next  = 1'b1;
            rem_next   = burst.cnt;
            bytes_next = burst.bytes;
        end else if (take) begin
            busy_next  = ~last;
            rem_next   = rem_reg - 3'd1;
            bytes_next = bytes_reg >> 8;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rem_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        if (burst_valid) begin
            err_reg <= burst.err;
            fin_reg <= burst.fin;
        end
    end

    assign m_valid        = busy_reg;
    assign m_utf8_byte    = bytes_reg[0];
    assign m_run_last     = last;
    assign m_output_end   = last & fin_reg;
    assign m_bad_sequence = err_reg;

    `U16U8_ASSERT_IMP(a_load_free, aclk, aresetn, burst_valid, burst_free, "burst loaded while busy")
    `U16U8_ASSERT_IMP(a_rem_range, aclk, aresetn, busy_reg, rem_reg != 3'd0 && rem_reg <= 3'd6, "word count out of range")
    `U16U8_ASSERT_NXT(a_stall_hold, aclk, aresetn, busy_reg && !m_ready, $stable(rem_reg) && $stable(bytes_reg[0]), "stalled burst moved")

endmodule

[design/utf16_to_utf8_encoder_core.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core
// Streams UTF-16 code units in and UTF-8 bytes out, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one UTF-16 code unit per word, s_string_end on the last
//   unit of a string. m_* channel: one UTF-8 byte per word, with run_last on
//   the last word caused by a unit and output_end on the last word of a
//   string; bad_sequence marks a strict-mode surrogate error (byte 0).
//   cfg_wr_en/cfg_index/cfg_wdata write replace_invalid (index 0) and
//   swap_input_bytes (index 1); write them only while the block is idle.
// Path: an accepted unit goes into the input register, then into the burst
//   register once that is free; its first byte is valid from there.
// Throughput: the output stage sends one byte per cycle while m_ready is
//   high; a unit causes n (0..6) bytes, and the burst register is the
//   limit. Units with no output go one per cycle while it is free.
// Reset: clears the held surrogate, the string failure flag and both
//   channels; replace_invalid resets to 1, swap_input_bytes to 0.
// Stall: with m_ready low the current byte holds, one more unit waits in
//   the input register, then s_ready drops.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_string_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_utf8_byte,
    output logic        m_run_last,
    output logic        m_output_end,
    output logic        m_bad_sequence
);

    logic              replace_reg;
    logic              swap_reg;
    logic              burst_valid;
    logic              burst_free;
    u16u8_pkg::burst_t burst;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replace_reg <= 1'b1;
            swap_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                u16u8_pkg::CfgReplaceInvalid: replace_reg <= cfg_wdata;
                u16u8_pkg::CfgSwapInputBytes: swap_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    u16u8_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_code_unit      (s_code_unit),
        .s_string_end     (s_string_end),
        .replace_invalid  (replace_reg),
        .swap_input_bytes (swap_reg),
        .burst_free       (burst_free),
        .burst_valid      (burst_valid),
        .burst            (burst)
    );

    u16u8_serial u_serial (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .burst_valid    (burst_valid),
        .burst          (burst),
        .burst_free     (burst_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_utf8_byte    (m_utf8_byte),
        .m_run_last     (m_run_last),
        .m_output_end   (m_output_end),
        .m_bad_sequence (m_bad_sequence)
    );

endmodule
